// ===== rtl/core/sidf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the signed integer digit formatter.
package sidf_pkg;

  localparam int unsigned MagBits   = 32;
  localparam int unsigned BcdDigits = 10;

  localparam logic [3:0] GLYPH_ZERO  = 4'd0;
  localparam logic [3:0] GLYPH_BLANK = 4'd10;
  localparam logic [3:0] GLYPH_MINUS = 4'd11;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;  // capture input item
    logic conv;  // one shift-add-3 step
    logic size;  // digit count, padding and write count
    logic emit;  // advance write index
  } sidf_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic range_err;  // current input rejected (combinational on inputs)
    logic conv_done;  // final conversion step in progress
    logic emit_last;  // current result is the final one
  } sidf_sts_t;

endpackage

// ===== rtl/core/signed_integer_digit_formatter.sv =====
`timescale 1ns / 1ps
// Top level of the signed integer digit formatter.
//
// Command port: an item (value, start position, field width, leading-zero
// flag) transfers on a rising edge with start high and busy low. busy stays
// high until the last result of that item has been shown.
// Result port: each result is valid for exactly one cycle with strobe_o
// high; the receiver cannot stall it. last_o marks the final result.
// Sequence: a rejected item (start + width past the display) gives its one
// result in the cycle after the transfer. Otherwise the magnitude
// runs through a 32-step shift-add-3 conversion, one bit per cycle, then
// a sizing step; the results then follow one per cycle, 1 to 9 of them.
// Items do not overlap: the next item transfers only once the last result
// of the one before has been shown.
// Reset: asynchronous, active low; returns the sequencer to idle with busy
// low. No item state is kept across items.
module signed_integer_digit_formatter #(
  parameter int unsigned NUM_DIGITS = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value_i,
  input  logic [3:0]         start_pos_i,
  input  logic [3:0]         field_width_i,
  input  logic               leading_zero_i,
  output logic               strobe_o,
  output logic [3:0]         position_o,
  output logic [3:0]         glyph_o,
  output logic               write_valid_o,
  output logic               range_error_o,
  output logic               last_o
);

  sidf_pkg::sidf_cmd_t cmd;
  sidf_pkg::sidf_sts_t sts;

  // Sequencer: owns busy and the result strobe.
  sidf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .strobe_o (strobe_o),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // Conversion and glyph selection; result fields come straight from here.
  sidf_datapath #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .value_i        (value_i),
    .start_pos_i    (start_pos_i),
    .field_width_i  (field_width_i),
    .leading_zero_i (leading_zero_i),
    .position_o     (position_o),
    .glyph_o        (glyph_o),
    .write_valid_o  (write_valid_o),
    .range_error_o  (range_error_o),
    .last_o         (last_o)
  );

  // Results only show up for an item in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni) strobe_o |-> busy)
    else $error("result strobe while idle");

  // The final result releases the command port.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (strobe_o && last_o) |=> !busy)
    else $error("busy held after last result");

  // A transfer always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("transfer did not raise busy");

  // A rejected item gives one result, with no write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (strobe_o && range_error_o) |-> (!write_valid_o && last_o))
    else $error("range error result malformed");

  // A write never lands past the display.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (strobe_o && write_valid_o) |-> (position_o < 4'(NUM_DIGITS)))
    else $error("write position out of range");

endmodule

// ===== rtl/core/sidf_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: magnitude, BCD conversion, field sizing and glyph selection.
module sidf_datapath #(
  parameter int unsigned NUM_DIGITS = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sidf_pkg::sidf_cmd_t cmd_i,
  output sidf_pkg::sidf_sts_t sts_o,
  input  logic signed [31:0]  value_i,
  input  logic [3:0]          start_pos_i,
  input  logic [3:0]          field_width_i,
  input  logic                leading_zero_i,
  output logic [3:0]          position_o,
  output logic [3:0]          glyph_o,
  output logic                write_valid_o,
  output logic                range_error_o,
  output logic                last_o
);

  localparam logic [4:0] NumDigitsW = 5'(NUM_DIGITS);

  logic [sidf_pkg::MagBits-1:0] mag_q, mag_d;
  logic [3:0] bcd_q [sidf_pkg::BcdDigits];
  logic [3:0] bcd_d [sidf_pkg::BcdDigits];
  logic [3:0] adj   [sidf_pkg::BcdDigits];
  logic [4:0] step_q;
  logic       neg_q, lz_q, err_q;
  logic [3:0] start_q, width_q;
  logic [3:0] cnt_q, pad_q, total_q, k_q;

  logic [3:0] sig, cnt_d, pad_d, total_d;
  logic [4:0] sum;
  logic       range_err;

  assign range_err = ({1'b0, start_pos_i} + {1'b0, field_width_i}) > NumDigitsW;
  assign mag_d     = value_i[31] ? (~$unsigned(value_i) + 32'd1) : $unsigned(value_i);

  // Shift-add-3 step over all BCD digits in parallel.
  always_comb begin
    for (int i = 0; i < sidf_pkg::BcdDigits; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    bcd_d[0] = {adj[0][2:0], mag_q[sidf_pkg::MagBits-1]};
    for (int i = 1; i < sidf_pkg::BcdDigits; i++) begin
      bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // Field sizing from the finished BCD digits.
  always_comb begin
    sig = 4'd0;
    for (int i = 0; i < sidf_pkg::BcdDigits; i++) begin
      if (bcd_q[i] != 4'd0) begin
        sig = 4'(i + 1);
      end
    end
    if (sig == 4'd0) begin
      cnt_d = 4'd1;  // zero shows as one digit
    end else if (sig > width_q) begin
      cnt_d = width_q;
    end else begin
      cnt_d = sig;
    end
    pad_d = ((lz_q || !neg_q) && (width_q > cnt_d)) ? width_q - cnt_d : 4'd0;
    sum   = {4'd0, neg_q} + {1'b0, pad_d} + {1'b0, cnt_d};
    total_d = (sum > {1'b0, width_q}) ? width_q : sum[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      k_q     <= '0;
      total_q <= '0;
      err_q   <= 1'b0;
    end else if (cmd_i.load) begin
      step_q  <= '0;
      k_q     <= '0;
      total_q <= '0;
      err_q   <= range_err;
    end else begin
      if (cmd_i.conv) begin
        step_q <= step_q + 5'd1;
      end
      if (cmd_i.size) begin
        total_q <= total_d;
      end
      if (cmd_i.emit) begin
        k_q <= k_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q   <= mag_d;
      neg_q   <= value_i[31];
      lz_q    <= leading_zero_i;
      start_q <= start_pos_i;
      width_q <= field_width_i;
      for (int i = 0; i < sidf_pkg::BcdDigits; i++) begin
        bcd_q[i] <= 4'd0;
      end
    end else if (cmd_i.conv) begin
      mag_q <= {mag_q[sidf_pkg::MagBits-2:0], 1'b0};
      bcd_q <= bcd_d;
    end
    if (cmd_i.size) begin
      cnt_q <= cnt_d;
      pad_q <= pad_d;
    end
  end

  // Write k: minus sign, then padding, then digits from the top down.
  logic [3:0] lead, j, idx, sel;
  always_comb begin
    lead = {3'd0, neg_q} + pad_q;
    j    = k_q - lead;
    idx  = cnt_q - 4'd1 - j;
    if (k_q < {3'd0, neg_q}) begin
      sel = sidf_pkg::GLYPH_MINUS;
    end else if (k_q < lead) begin
      sel = lz_q ? sidf_pkg::GLYPH_ZERO : sidf_pkg::GLYPH_BLANK;
    end else if (idx < 4'(sidf_pkg::BcdDigits)) begin
      sel = bcd_q[idx];
    end else begin
      sel = sidf_pkg::GLYPH_ZERO;
    end
  end

  assign write_valid_o = !err_q && (total_q != 4'd0);
  assign range_error_o = err_q;
  assign last_o        = err_q || (total_q == 4'd0) || (k_q == total_q - 4'd1);
  assign position_o    = write_valid_o ? start_q + k_q : 4'd0;
  assign glyph_o       = write_valid_o ? sel : 4'd0;

  assign sts_o.range_err = range_err;
  assign sts_o.conv_done = (step_q == 5'd31);
  assign sts_o.emit_last = last_o;

endmodule

// ===== rtl/core/sidf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences load, conversion, sizing and result emission.
module sidf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                strobe_o,
  output sidf_pkg::sidf_cmd_t cmd_o,
  input  sidf_pkg::sidf_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIZE = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    strobe_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          // Rejected items go straight to their single result.
          state_d = sts_i.range_err ? ST_EMIT : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_done) begin
          state_d = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        strobe_o   = 1'b1;
        if (sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule
